// ===== rtl/tx_ring_queue_byte_count_macros.svh =====
// Assertion macros for the transmit ring queue.
// Used by the top level only; each expects clk and rst_n in scope.
`ifndef TX_RING_QUEUE_BYTE_COUNT_MACROS_SVH
`define TX_RING_QUEUE_BYTE_COUNT_MACROS_SVH

// The consequent must hold in the cycle after the antecedent.
`define TXQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("transmit queue check failed");

// The consequent must hold in the same cycle as the antecedent.
`define TXQ_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("transmit queue check failed");

`endif

// ===== rtl/txq_pkg.sv =====
// Shared types and constants of the transmit ring queue.
// No dependencies; imported by the top level of the block; the RAM does not use it.
package txq_pkg;

  localparam int DEPTH = 256;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH);
  localparam int HANDLE_W = 32;
  localparam int LEN_W = 16;
  localparam int BYTES_W = 24;
  localparam int WORD_W = HANDLE_W + LEN_W;

  localparam logic OP_PUT = 1'b0;
  localparam logic OP_GET = 1'b1;

  localparam logic [1:0] STATUS_OK = 2'd0;
  localparam logic [1:0] STATUS_FULL = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  typedef struct packed {
    logic                operation;
    logic [HANDLE_W-1:0] handle_in;
    logic [LEN_W-1:0]    length_in;
  } in_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle_out;
    logic                got_entry;
    logic [1:0]          status;
    logic [7:0]          used_slots;
    logic [7:0]          free_slots;
    logic [BYTES_W-1:0]  stored_bytes;
  } out_t;

  // Request from the queue control to the entry memory.
  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [WORD_W-1:0] wr_data;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
  } mem_req_t;

endpackage

// ===== rtl/txq_ram.sv =====
// Simple dual-port synchronous RAM with one write and one registered read port.
// Generic; holds the handle and length of every queue slot.
module txq_ram #(
  parameter int DATA_W = 48,
  parameter int ADDR_W = 8,
  parameter int WORDS = 256
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [WORDS];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/tx_ring_queue_byte_count.sv =====
// Put: result registered in the cycle after acceptance; accepted every cycle
// while no get waits and the output is not stalled. Get: the entry memory
// is read on acceptance; the result comes from the read state, in which
// no item is accepted. Output stall holds the result register and blocks
// further acceptance. Reset (rst_n low, synchronous) empties the queue and
// zeroes the byte total; the entry memory needs no clearing pass.
module tx_ring_queue_byte_count
  import txq_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_READ = 1'b1;

  logic               state_r, state_nxt;
  logic [IDX_W-1:0]   wr_idx_r, wr_idx_nxt;
  logic [IDX_W-1:0]   rd_idx_r, rd_idx_nxt;
  logic [CNT_W-1:0]   used_r, used_nxt;
  logic [BYTES_W-1:0] bytes_r, bytes_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_t               out_data_r, out_data_nxt;

  mem_req_t           mem_req;
  logic [WORD_W-1:0]  rd_word;
  logic               out_free;
  logic               accept;
  logic               is_full;
  logic               is_empty;
  logic [CNT_W-1:0]   free_cnt;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r == ST_READ) || !out_free;
  assign accept   = in_valid && !in_stall;
  assign is_full  = (used_r == CNT_W'(DEPTH - 1));
  assign is_empty = (used_r == '0);
  assign free_cnt = CNT_W'(DEPTH - 1) - used_nxt;

  function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] idx);
    return (idx == IDX_W'(DEPTH - 1)) ? '0 : idx + 1'b1;
  endfunction

  always_comb begin
    state_nxt     = state_r;
    wr_idx_nxt    = wr_idx_r;
    rd_idx_nxt    = rd_idx_r;
    used_nxt      = used_r;
    bytes_nxt     = bytes_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;

    mem_req.wr_en   = 1'b0;
    mem_req.wr_addr = wr_idx_r;
    mem_req.wr_data = {in_data.length_in, in_data.handle_in};
    mem_req.rd_en   = 1'b0;
    mem_req.rd_addr = rd_idx_r;

    out_data_nxt.handle_out = out_data_r.handle_out;
    out_data_nxt.got_entry  = out_data_r.got_entry;
    out_data_nxt.status     = out_data_r.status;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_data.operation == OP_PUT) begin
            out_valid_nxt           = 1'b1;
            out_data_nxt.handle_out = '0;
            out_data_nxt.got_entry  = 1'b0;
            if (is_full) begin
              out_data_nxt.status = STATUS_FULL;
            end else begin
              out_data_nxt.status = STATUS_OK;
              mem_req.wr_en       = 1'b1;
              wr_idx_nxt          = ring_next(wr_idx_r);
              used_nxt            = used_r + 1'b1;
              bytes_nxt           = bytes_r + BYTES_W'(in_data.length_in);
            end
          end else if (is_empty) begin
            out_valid_nxt           = 1'b1;
            out_data_nxt.handle_out = '0;
            out_data_nxt.got_entry  = 1'b0;
            out_data_nxt.status     = STATUS_EMPTY;
          end else begin
            // The entry arrives from memory next cycle; finish the get in the read state once the output is free.
            mem_req.rd_en = 1'b1;
            state_nxt     = ST_READ;
          end
        end
      end
      ST_READ: begin
        if (out_free) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.handle_out = rd_word[HANDLE_W-1:0];
          out_data_nxt.got_entry  = 1'b1;
          out_data_nxt.status     = STATUS_OK;
          rd_idx_nxt              = ring_next(rd_idx_r);
          used_nxt                = used_r - 1'b1;
          bytes_nxt = bytes_r - BYTES_W'(rd_word[WORD_W-1:HANDLE_W]);
          state_nxt               = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    out_data_nxt.used_slots   = 8'(used_nxt);
    out_data_nxt.free_slots   = 8'(free_cnt);
    out_data_nxt.stored_bytes = bytes_nxt;
    if (!out_free) begin
      out_data_nxt = out_data_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wr_idx_r    <= '0;
      rd_idx_r    <= '0;
      used_r      <= '0;
      bytes_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wr_idx_r    <= wr_idx_nxt;
      rd_idx_r    <= rd_idx_nxt;
      used_r      <= used_nxt;
      bytes_r     <= bytes_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  txq_ram #(
    .DATA_W(WORD_W),
    .ADDR_W(IDX_W),
    .WORDS (DEPTH)
  ) u_ram (
    .clk    (clk),
    .wr_en  (mem_req.wr_en),
    .wr_addr(mem_req.wr_addr),
    .wr_data(mem_req.wr_data),
    .rd_en  (mem_req.rd_en),
    .rd_addr(mem_req.rd_addr),
    .rd_data(rd_word)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`include "tx_ring_queue_byte_count_macros.svh"

  // A get on a non-empty queue enters the read state to wait for its entry and gives no new result yet.
  `TXQ_ASSERT_NEXT(a_get_reads, accept && in_data.operation == OP_GET && !is_empty, state_r == ST_READ && out_valid_r == $past(out_valid_r && out_stall))
  // A refused put leaves the ring untouched and reports full.
  `TXQ_ASSERT_NEXT(a_full_refused, accept && in_data.operation == OP_PUT && is_full, $stable(wr_idx_r) && $stable(bytes_r) && out_data_r.status == STATUS_FULL)
  // An accepted put on a non-full queue adds exactly one entry.
  `TXQ_ASSERT_NEXT(a_put_counts, accept && in_data.operation == OP_PUT && !is_full, used_r == $past(used_r) + 1'b1)
  // A result that removed an entry always reports success.
  `TXQ_ASSERT_NOW(a_got_ok, out_valid_r && out_data_r.got_entry, out_data_r.status == STATUS_OK)

endmodule
